/* design/assert_macros.svh */
// Assertion macros used by the RTL of the sorted list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk, masked while rst_n is low.
`define SLE_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication checked at every rising edge of clk.
`define SLE_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* design/sle_pkg.sv */
// Package with the types and constants of the sorted list engine.
`default_nettype none
package sle_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;
  localparam int ECNT_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT    = 3'd0,
    FN_REM_FIRST = 3'd1,
    FN_REM_LAST  = 3'd2,
    FN_REM_VALUE = 3'd3,
    FN_SEARCH    = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Request broadcast to every cell of the chain.
  typedef struct packed {
    logic                    do_insert;
    logic                    do_rem_first;
    logic                    do_rem_value;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage
`default_nettype wire

/* design/sorted_list_engine.sv */
// Top level of the sorted list engine: request stage, cell chain and result register.
//
//   Channel   Direction  Ports                                  Handshake
//   request   in         in_func, in_value                      in_valid / in_ready
//   result    out        out_status, out_removed_value,         out_valid / out_ready
//                        out_entry_count
//
// A request is captured in the request register. Once the result register is free or
// being read, every cell compares its entry with the request value in parallel and
// shifts and the result register is loaded; the request register holds one request.
// Reset empties the list at once (the count goes to zero); there is no sweep.
// A result waiting on out_ready keeps the next request in the request register, and
// in_ready stays low until the chain has taken that request.
`default_nettype none
`include "assert_macros.svh"
module sorted_list_engine
  import sle_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [FUNC_W-1:0]        in_func,
  input  wire logic signed [VAL_W-1:0]  in_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [STAT_W-1:0]             out_status,
  output logic signed [VAL_W-1:0]       out_removed_value,
  output logic [ECNT_W-1:0]             out_entry_count
);

  // Request register.
  logic                    req_valid_r;
  logic [FUNC_W-1:0]       req_func_r;
  logic signed [VAL_W-1:0] req_value_r;

  // Occupancy and the result register.
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        cnt_nxt;
  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [STAT_W-1:0]       status_nxt;
  logic signed [VAL_W-1:0] out_removed_r;
  logic signed [VAL_W-1:0] removed_nxt;
  logic [ECNT_W-1:0]       out_count_r;
  logic [CNT_W+ECNT_W-1:0] cnt_ext;

  logic      go;
  logic      full;
  logic      empty;
  logic      hit;
  cell_cmd_t cmd;

  // Chain wiring.
  logic [DEPTH-1:0]              occ_w;
  logic [DEPTH-1:0]              take_w;
  logic [DEPTH-1:0]              eq_w;
  logic signed [VAL_W-1:0]       val_w  [DEPTH];
  logic signed [VAL_W-1:0]       last_w [DEPTH];
  logic signed [VAL_W-1:0]       last_value;

  // The request register frees up when the request is processed, so the
  // input side only waits on a request that has not reached the chain yet.
  assign in_ready = !req_valid_r;
  assign go       = req_valid_r && (!out_valid_r || out_ready);

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign hit   = |eq_w;

  // Only successful changes reach the cells; everything else leaves them alone.
  always_comb begin
    cmd.value        = req_value_r;
    cmd.do_insert    = (req_func_r == FN_INSERT) && !full;
    cmd.do_rem_first = (req_func_r == FN_REM_FIRST) && !empty;
    cmd.do_rem_value = (req_func_r == FN_REM_VALUE) && !empty && hit;
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                    left_take;
      logic signed [VAL_W-1:0] left_value;
      logic signed [VAL_W-1:0] right_value;
      logic                    next_occ;

      assign occ_w[gi] = (CNT_W'(gi) < cnt_r);

      if (gi == 0) begin : g_head
        assign left_take  = 1'b0;
        assign left_value = '0;
      end else begin : g_body
        assign left_take  = take_w[gi-1];
        assign left_value = val_w[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign right_value = '0;
        assign next_occ    = 1'b0;
      end else begin : g_inner
        assign right_value = val_w[gi+1];
        assign next_occ    = occ_w[gi+1];
      end

      // The last occupied cell drives the value for a remove from the back.
      assign last_w[gi] = (occ_w[gi] && !next_occ) ? val_w[gi] : '0;

      sle_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occ         (occ_w[gi]),
        .left_take   (left_take),
        .left_value  (left_value),
        .right_value (right_value),
        .go          (go),
        .take        (take_w[gi]),
        .eq          (eq_w[gi]),
        .value       (val_w[gi])
      );
    end
  endgenerate

  always_comb begin
    last_value = '0;
    for (int k = 0; k < DEPTH; k++) begin
      last_value = last_value | last_w[k];
    end
  end

  // Result and next occupancy of the request in the chain stage.
  always_comb begin
    status_nxt  = ST_OK;
    removed_nxt = '0;
    cnt_nxt     = cnt_r;
    unique case (req_func_r)
      FN_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      FN_REM_FIRST: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          removed_nxt = val_w[0];
          cnt_nxt     = cnt_r - CNT_W'(1);
        end
      end
      FN_REM_LAST: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          removed_nxt = last_value;
          cnt_nxt     = cnt_r - CNT_W'(1);
        end
      end
      FN_REM_VALUE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!hit) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          removed_nxt = req_value_r;
          cnt_nxt     = cnt_r - CNT_W'(1);
        end
      end
      FN_SEARCH: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!hit) begin
          status_nxt = ST_NOTFOUND;
        end
      end
      default: begin
        // Undefined codes leave the list alone and report ok.
      end
    endcase
  end

  // The entry count port shows the low bits of the occupancy.
  assign cnt_ext = {{ECNT_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (in_valid && in_ready) begin
        req_valid_r <= 1'b1;
      end else if (go) begin
        req_valid_r <= 1'b0;
      end

      if (go) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_func_r  <= in_func;
      req_value_r <= in_value;
    end
    if (go) begin
      out_status_r  <= status_nxt;
      out_removed_r <= removed_nxt;
      out_count_r   <= cnt_ext[ECNT_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_entry_count   = out_count_r;

  // The occupancy never passes the depth of the chain.
  `SLE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "occupancy above depth")
  // A processed request always leaves a result behind.
  `SLE_ASSERT_NXT(a_go_result, go, out_valid_r, "processed request gave no result")
  // The occupancy moves by at most one entry per cycle.
  `SLE_ASSERT_NXT(a_cnt_step, 1'b1,
    (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + CNT_W'(1)) ||
    (cnt_r == $past(cnt_r) - CNT_W'(1)), "occupancy jumped")
  // A waiting result shows the current occupancy.
  `SLE_ASSERT_IMP(a_out_count, out_valid_r,
    out_count_r == ECNT_W'({{ECNT_W{1'b0}}, cnt_r}), "result count out of step")

endmodule
`default_nettype wire

/* design/sle_cell.sv */
// One storage cell of the sorted chain, with its compare and shift logic.
`default_nettype none
module sle_cell
  import sle_pkg::*;
(
  input  wire logic                    clk,
  input  wire cell_cmd_t               cmd,
  input  wire logic                    occ,
  input  wire logic                    left_take,
  input  wire logic signed [VAL_W-1:0] left_value,
  input  wire logic signed [VAL_W-1:0] right_value,
  input  wire logic                    go,
  output logic                         take,
  output logic                         eq,
  output logic signed [VAL_W-1:0]      value
);

  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] value_nxt;

  // A free cell or one holding a value not below the request marks the
  // insert point and everything after it; the flags are monotonic along the chain.
  assign take  = !occ || (value_r >= cmd.value);
  assign eq    = occ && (value_r == cmd.value);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    priority if (cmd.do_insert) begin
      if (left_take) begin
        value_nxt = left_value;
      end else if (take) begin
        value_nxt = cmd.value;
      end
    end else if (cmd.do_rem_first) begin
      value_nxt = right_value;
    end else if (cmd.do_rem_value && take) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      value_r <= value_nxt;
    end
  end

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Testbench for the sorted list engine: directed table, random episodes and a result scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  // The func field is three bits wide, but only five codes mean something.
  // The block must answer the other three with an unchanged list.
  localparam logic [FUNC_W-1:0] FN_RSVD_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FN_RSVD_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD_7 = 3'd7;

  localparam int RANDOM_REQUESTS = 1900;
  localparam int HOLD_OFF_AT     = 400;   // results seen before the long hold-off
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int MAX_REPORTS     = 10;
  localparam int DRAIN_CYCLES    = 20;
  localparam int TIMEOUT_NS      = 20_000_000;

  localparam logic signed [VAL_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  localparam logic signed [VAL_W-1:0] EDGE_VALUES [6] = '{
    INT_MIN, INT_MIN + 32'sd1, -32'sd1, 32'sd0, INT_MAX - 32'sd1, INT_MAX
  };

  // One result of the block, in port order.
  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] removed;
    logic [ECNT_W-1:0]       count;
  } list_result_t;

  // One row of the directed table. Where known is set, the result is typed in
  // by hand; otherwise the predictor supplies it.
  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [VAL_W-1:0] value;
    logic                    known;
    list_result_t            result;
  } request_row_t;

  localparam int DIRECTED_LEN = 25;

  localparam request_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    // Removes, search and a reserved code on the empty list right after reset.
    '{FN_REM_FIRST, 32'sd0,  1'b1, '{ST_EMPTY, 32'sd0, 5'd0}},
    '{FN_REM_LAST,  32'sd0,  1'b1, '{ST_EMPTY, 32'sd0, 5'd0}},
    '{FN_REM_VALUE, 32'sd5,  1'b1, '{ST_EMPTY, 32'sd0, 5'd0}},
    '{FN_SEARCH,    32'sd5,  1'b1, '{ST_EMPTY, 32'sd0, 5'd0}},
    '{FN_RSVD_5,    32'sd5,  1'b1, '{ST_OK,    32'sd0, 5'd0}},
    // Both value extremes, a duplicate, a search hit and miss, then a reserved code.
    '{FN_INSERT,    INT_MIN, 1'b1, '{ST_OK,    32'sd0, 5'd1}},
    '{FN_INSERT,    INT_MAX, 1'b1, '{ST_OK,    32'sd0, 5'd2}},
    '{FN_INSERT,    32'sd0,  1'b1, '{ST_OK,    32'sd0, 5'd3}},
    '{FN_INSERT,    32'sd0,  1'b1, '{ST_OK,    32'sd0, 5'd4}},
    '{FN_INSERT,    -32'sd1, 1'b1, '{ST_OK,    32'sd0, 5'd5}},
    '{FN_SEARCH,    32'sd0,  1'b1, '{ST_OK,    32'sd0, 5'd5}},
    '{FN_SEARCH,    32'sd1,  1'b1, '{ST_NOTFOUND, 32'sd0, 5'd5}},
    '{FN_RSVD_6,    -32'sd1, 1'b1, '{ST_OK,    32'sd0, 5'd5}},
    // Both ends come out, the remove-value miss and hit, a reserved code, then the rest.
    '{FN_REM_FIRST, 32'sd0,  1'b1, '{ST_OK,    INT_MIN, 5'd4}},
    '{FN_REM_LAST,  32'sd0,  1'b1, '{ST_OK,    INT_MAX, 5'd3}},
    '{FN_REM_VALUE, 32'sd7,  1'b1, '{ST_NOTFOUND, 32'sd0, 5'd3}},
    '{FN_REM_VALUE, 32'sd0,  1'b1, '{ST_OK,    32'sd0, 5'd2}},
    '{FN_RSVD_7,    INT_MAX, 1'b1, '{ST_OK,    32'sd0, 5'd2}},
    '{FN_REM_FIRST, 32'sd0,  1'b1, '{ST_OK,    -32'sd1, 5'd1}},
    '{FN_REM_FIRST, 32'sd0,  1'b1, '{ST_OK,    32'sd0, 5'd0}},
    // A few more left to the predictor.
    '{FN_INSERT,    32'sd42, 1'b0, '0},
    '{FN_INSERT,    -32'sd42, 1'b0, '0},
    '{FN_SEARCH,    -32'sd42, 1'b0, '0},
    '{FN_REM_VALUE, 32'sd42, 1'b0, '0},
    '{FN_REM_LAST,  32'sd0,  1'b0, '0}
  };

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [FUNC_W-1:0]       in_func;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [STAT_W-1:0]       out_status;
  logic signed [VAL_W-1:0] out_removed_value;
  logic [ECNT_W-1:0]       out_entry_count;

  // The predictor's copy of the list, kept in ascending order. It is updated
  // when a request is accepted, so the stimulus can also peek at it to pick
  // values that are really present.
  logic signed [VAL_W-1:0] list_contents[$];

  // Results still owed by the block, oldest first.
  list_result_t pending_results[$];

  int failures     = 0;
  int results_seen = 0;

  always #5 clk = ~clk;

  sorted_list_engine DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_entry_count   (out_entry_count)
  );

  // Applies one request to the list copy and returns what the block should
  // answer. A remove hands back the entry it took; everything else reports
  // zero in that field. The count is the occupancy cut to the port width.
  function automatic list_result_t predict_list_op(input logic [FUNC_W-1:0] func,
                                                   input logic signed [VAL_W-1:0] value);
    list_result_t res;
    int           pos;
    int           hit;
    res = '{ST_OK, 32'sd0, 5'd0};
    hit = -1;
    for (int k = 0; k < list_contents.size(); k++) begin
      if (hit < 0 && list_contents[k] == value) begin
        hit = k;
      end
    end
    case (func)
      FN_INSERT: begin
        if (list_contents.size() >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // The new value goes in front of the first entry that is not smaller.
          pos = 0;
          while (pos < list_contents.size() && list_contents[pos] < value) begin
            pos++;
          end
          list_contents.insert(pos, value);
        end
      end
      FN_REM_FIRST: begin
        if (list_contents.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed = list_contents.pop_front();
        end
      end
      FN_REM_LAST: begin
        if (list_contents.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed = list_contents.pop_back();
        end
      end
      FN_REM_VALUE: begin
        if (list_contents.size() == 0) begin
          res.status = ST_EMPTY;
        end else if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.removed = list_contents[hit];
          list_contents.delete(hit);
        end
      end
      FN_SEARCH: begin
        if (list_contents.size() == 0) begin
          res.status = ST_EMPTY;
        end else if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end
      end
      default: begin
        // Reserved codes leave the list alone and report ok.
      end
    endcase
    res.count = ECNT_W'(list_contents.size());
    return res;
  endfunction

  // Idle stretch for either side: mostly short, now and then long.
  function automatic int pick_idle_len();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Picks a func code to suit the current episode. Filling episodes push the
  // list against its upper bound, draining ones against empty.
  function automatic logic [FUNC_W-1:0] pick_func(input int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      return FUNC_W'($urandom_range(FN_RSVD_5, FN_RSVD_7));
    end
    roll = $urandom_range(0, 99);
    case (mode)
      0: return (roll < 75) ? FN_INSERT : FUNC_W'($urandom_range(1, 4));
      1: return (roll < 20) ? FN_INSERT : FUNC_W'($urandom_range(1, 4));
      2: return FUNC_W'($urandom_range(0, 4));
      default: begin
        if (roll < 35) return FN_INSERT;
        if (roll < 70) return FN_REM_VALUE;
        return FN_SEARCH;
      end
    endcase
  endfunction

  // Values cluster on a small range so duplicates and hits are common, with
  // the extremes and fully random words mixed in.
  function automatic logic signed [VAL_W-1:0] pick_value(input logic [FUNC_W-1:0] func);
    int roll;
    roll = $urandom_range(0, 99);
    if ((func == FN_REM_VALUE || func == FN_SEARCH) && list_contents.size() > 0 &&
        roll < 60) begin
      return list_contents[$urandom_range(0, list_contents.size() - 1)];
    end
    roll = $urandom_range(0, 99);
    if (roll < 35) return VAL_W'($signed($urandom_range(0, 8)) - 4);
    if (roll < 45) return EDGE_VALUES[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  function automatic void note_failure(input string what, input list_result_t want,
                                       input list_result_t got);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%0t: %s: expected %0d/%0d/%0d, got %0d/%0d/%0d (status/removed/count)",
               $realtime, what, want.status, want.removed, want.count,
               got.status, got.removed, got.count);
    end
  endfunction

  // Offers one request after an optional gap and holds it until accepted.
  // Valid is only lowered when a gap follows, so a back-to-back request never
  // sees valid dropped and raised in the same time step.
  task automatic offer_request(input logic [FUNC_W-1:0] func,
                               input logic signed [VAL_W-1:0] value,
                               input bit back_to_back, input logic known,
                               input list_result_t given);
    int           gap;
    list_result_t predicted;
    gap = 0;
    if (!back_to_back && $urandom_range(0, 99) >= 55) begin
      gap = pick_idle_len();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Accepted at this edge: the predictor always advances, even for rows
    // whose answer was typed in.
    predicted = predict_list_op(func, value);
    pending_results.push_back(known ? given : predicted);
  endtask

  // Request side: reset, the directed table, then random episodes.
  initial begin : request_source
    int                      requests_sent;
    int                      mode;
    int                      len;
    bit                      back_to_back;
    logic [FUNC_W-1:0]       func;
    logic signed [VAL_W-1:0] value;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_func       = '0;
    in_value      = '0;
    requests_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_LEN; r++) begin
      offer_request(DIRECTED_ROWS[r].func, DIRECTED_ROWS[r].value, 1'b0,
                    DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].result);
    end

    // Episodes of 10 to 60 requests each. Some run with no gaps at all so
    // the block sees its full request rate.
    while (requests_sent < RANDOM_REQUESTS) begin
      mode         = $urandom_range(0, 3);
      len          = $urandom_range(10, 60);
      back_to_back = ($urandom_range(0, 3) == 0);
      repeat (len) begin
        func  = pick_func(mode);
        value = pick_value(func);
        offer_request(func, value, back_to_back, 1'b0, '0);
        if (func <= FN_SEARCH) begin
          requests_sent++;
        end
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // Drain stretch to catch any result the block should not produce.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: checks each accepted result against the oldest expectation
  // and drives out_ready with random stalls, plus one long hold-off that lets
  // the block back up and stall its input.
  initial begin : result_sink
    int           stall_left;
    int           hold_count;
    bit           held_off;
    bit           steady;
    list_result_t got;
    list_result_t want;
    out_ready  = 1'b0;
    stall_left = 0;
    held_off   = 1'b0;
    steady     = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = '{out_status, out_removed_value, out_entry_count};
        results_seen++;
        if (pending_results.size() == 0) begin
          note_failure("result with no request outstanding", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            note_failure("status mismatch", want, got);
          end else if (got.removed !== want.removed) begin
            note_failure("removed value mismatch", want, got);
          end else if (got.count !== want.count) begin
            note_failure("entry count mismatch", want, got);
          end
        end
      end

      // Now and then switch to a stretch where the receiver never stalls.
      if ($urandom_range(0, 149) == 0) begin
        steady = ~steady;
      end

      if (!held_off && results_seen >= HOLD_OFF_AT) begin
        held_off   = 1'b1;
        out_ready <= 1'b0;
        hold_count = 0;
        while (hold_count < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          hold_count++;
        end
        out_ready <= 1'b1;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 9) < 7) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left = pick_idle_len() - 1;
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/sle_pkg.sv
design/sle_cell.sv
design/sorted_list_engine.sv
sim/tb_top.sv
